[rtl/core/bezier_path_flattener_top_assert.svh]
// assertion macros for the path flattener
// expects clk_i and rst_ni in the scope of each use
`ifndef BEZIER_PATH_FLATTENER_TOP_ASSERT_SVH
`define BEZIER_PATH_FLATTENER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BPF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BPF_ASSERT(lbl, prop)
`define BPF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/bpf_pkg.sv]
// package for the path flattener: types, codes, constants and helpers
// no dependencies
package bpf_pkg;

  localparam int MAX_DEPTH = 6;
  localparam int COORD_W   = 16;
  localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
  localparam int DIST_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIST_W;
  localparam int POLY_W    = DIST_W + 2;
  localparam int FF_W      = 11;
  localparam int THR_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FLATNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL    = 2'd1;
  localparam logic [FF_W-1:0]      FF_RESET     = 11'd259;
  localparam logic [THR_W-1:0]     THR_RESET    = 8'd3;

  typedef enum logic [2:0] {
    ACT_BEGIN = 3'd0,
    ACT_MOVE  = 3'd1,
    ACT_LINE  = 3'd2,
    ACT_QUAD  = 3'd3,
    ACT_CUBIC = 3'd4,
    ACT_CLOSE = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_DECIDE, ST_SPLIT, ST_EMIT, ST_POP, ST_LOAD
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  typedef struct packed {
    pt_t c1;
    pt_t c2;
    pt_t e;
  } seg_t;

  function automatic pt_t mid(pt_t a, pt_t b);
    logic signed [COORD_W:0] sx;
    logic signed [COORD_W:0] sy;
    pt_t r;
    sx = {a.x[COORD_W-1], a.x} + {b.x[COORD_W-1], b.x};
    sy = {a.y[COORD_W-1], a.y} + {b.y[COORD_W-1], b.y};
    r.x = sx[COORD_W:1];
    r.y = sy[COORD_W:1];
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] absdiff(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
    logic signed [DIST_W-1:0] d;
    d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    return d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
  endfunction

endpackage

[rtl/core/bpf_cmd_if.sv]
// command channel: one path command per beat
// depends on bpf_pkg
interface bpf_cmd_if import bpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] ctl1_x;
  logic signed [COORD_W-1:0] ctl1_y;
  logic signed [COORD_W-1:0] ctl2_x;
  logic signed [COORD_W-1:0] ctl2_y;
  modport source (output valid, action, end_x, end_y, ctl1_x, ctl1_y, ctl2_x, ctl2_y,
                  input ready);
  modport sink (input valid, action, end_x, end_y, ctl1_x, ctl1_y, ctl2_x, ctl2_y,
                output ready);
endinterface

[rtl/core/bpf_pt_if.sv]
// point channel: one polyline vertex per beat
// depends on bpf_pkg
interface bpf_pt_if import bpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last;
  modport source (output valid, point_x, point_y, last, input ready);
  modport sink (input valid, point_x, point_y, last, output ready);
endinterface

[rtl/core/bpf_cfg_if.sv]
// register write channel
// depends on bpf_pkg
interface bpf_cfg_if import bpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/bpf_ram.sv]
// generic single write port ram with registered read
// no dependencies
module bpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/core/bezier_path_flattener_top.sv]
// Path flattener. Begin and move are handled in the idle state; line and close go on
// to emit a point, which may wait on the point channel. Each curve piece is judged by four
// distances, computed one after another on one shared 17x17 multiplier and a
// bit-serial square root, followed by the decision. A split pushes the right half onto
// the stack, and resuming a pending right half reads it back (stack read). A curve that
// emits n points checks 2n-1 pieces; up to 64 points per command.
// The command channel is ready only while no command is in work.
// depends on bpf_pkg, the channel interfaces, bpf_ram and the assertion header
`include "bezier_path_flattener_top_assert.svh"
module bezier_path_flattener_top import bpf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  bpf_cmd_if.sink cmd_i,
  bpf_cfg_if.sink cfg_i,
  bpf_pt_if.source pt_o
);
  localparam int RAM_AW = $clog2(MAX_DEPTH);
  localparam int ROOT_STEPS = SQ_W / 2;

  state_e state_q, state_d;
  pt_t cur_q, cur_d, start_q, start_d;
  seg_t seg_q, seg_d;
  logic cubic_q, cubic_d;
  logic [LVL_W-1:0] depth_q, depth_d, level_q, level_d;
  logic [1:0] didx_q, didx_d;
  logic [SQ_W-1:0] sq_q, sq_d, rad_q, rad_d;
  logic [DIST_W+2:0] rem_q, rem_d;
  logic [DIST_W-1:0] root_q, root_d, chord_q, chord_d;
  logic [4:0] it_q, it_d;
  logic [POLY_W-1:0] poly_q, poly_d;
  logic [FF_W-1:0] ff_q;
  logic [THR_W-1:0] thr_q;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d;
  pt_t out_pt_q, out_pt_d;
  logic emit_last_q, emit_last_d;

  pt_t da, db;
  logic [DIST_W-1:0] mul_a, mul_b;
  logic [SQ_W-1:0] prod;
  logic [DIST_W+2:0] rem_sh, trial;
  logic split;
  logic out_free;
  pt_t m1, m2, m3, m4, m5, m6;
  seg_t left, right;
  logic ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [$bits(seg_t)-1:0] ram_rdata;
  pt_t in_e, in_c1, in_c2;

  assign in_e  = '{x: cmd_i.end_x,  y: cmd_i.end_y};
  assign in_c1 = '{x: cmd_i.ctl1_x, y: cmd_i.ctl1_y};
  assign in_c2 = '{x: cmd_i.ctl2_x, y: cmd_i.ctl2_y};

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign pt_o.valid = out_valid_q;
  assign pt_o.point_x = out_pt_q.x;
  assign pt_o.point_y = out_pt_q.y;
  assign pt_o.last = out_last_q;
  assign out_free = !out_valid_q || pt_o.ready;

  // distance operands
  always_comb begin
    case (didx_q)
      2'd0: begin da = cur_q;    db = seg_q.e;  end
      2'd1: begin da = cur_q;    db = seg_q.c1; end
      2'd2: begin da = seg_q.c1; db = seg_q.c2; end
      default: begin da = seg_q.c2; db = seg_q.e; end
    endcase
  end

  // shared multiplier
  always_comb begin
    case (state_q)
      ST_SQX: begin
        mul_a = absdiff(da.x, db.x);
        mul_b = mul_a;
      end
      ST_SQY: begin
        mul_a = absdiff(da.y, db.y);
        mul_b = mul_a;
      end
      default: begin
        mul_a = DIST_W'(ff_q);
        mul_b = chord_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign rem_sh = {rem_q[DIST_W:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign split = (depth_q < LVL_W'(MAX_DEPTH)) && (level_q < LVL_W'(MAX_DEPTH)) &&
                 (SQ_W'({poly_q, 8'h00}) > prod) &&
                 (poly_q > POLY_W'(chord_q) + POLY_W'(thr_q));

  // subdivision
  always_comb begin
    if (cubic_q) begin
      m1 = mid(cur_q, seg_q.c1);
      m2 = mid(seg_q.c1, seg_q.c2);
      m3 = mid(seg_q.c2, seg_q.e);
      m4 = mid(m1, m2);
      m5 = mid(m2, m3);
      m6 = mid(m4, m5);
      left  = '{c1: m1, c2: m4, e: m6};
      right = '{c1: m5, c2: m3, e: seg_q.e};
    end else begin
      m1 = mid(cur_q, seg_q.c1);
      m2 = mid(seg_q.c1, seg_q.e);
      m3 = mid(m1, m2);
      m4 = m1;
      m5 = m2;
      m6 = m3;
      left  = '{c1: m1, c2: m4, e: m6};
      right = '{c1: m5, c2: m5, e: seg_q.e};
    end
  end

  assign ram_we    = (state_q == ST_SPLIT);
  assign ram_waddr = level_q[RAM_AW-1:0];
  assign ram_raddr = RAM_AW'(level_q - LVL_W'(1));

  bpf_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (right),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          case (cmd_i.action)
            ACT_LINE, ACT_CLOSE: state_d = ST_EMIT;
            ACT_QUAD, ACT_CUBIC: state_d = ST_SQX;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SQX: state_d = ST_SQY;
      ST_SQY: state_d = ST_ROOT;
      ST_ROOT: begin
        if (it_q == 5'(ROOT_STEPS - 1)) begin
          state_d = (didx_q == 2'd3) ? ST_DECIDE : ST_SQX;
        end
      end
      ST_DECIDE: state_d = split ? ST_SPLIT : ST_EMIT;
      ST_SPLIT: state_d = ST_SQX;
      ST_EMIT: begin
        if (out_free) begin
          state_d = (level_q == '0) ? ST_IDLE : ST_POP;
        end
      end
      ST_POP: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_SQX;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cur_d = cur_q;
    start_d = start_q;
    seg_d = seg_q;
    cubic_d = cubic_q;
    depth_d = depth_q;
    level_d = level_q;
    didx_d = didx_q;
    sq_d = sq_q;
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    it_d = it_q;
    chord_d = chord_q;
    poly_d = poly_q;
    emit_last_d = emit_last_q;
    out_valid_d = out_valid_q && !pt_o.ready;
    out_pt_d = out_pt_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        didx_d = '0;
        poly_d = '0;
        depth_d = '0;
        level_d = '0;
        cubic_d = (cmd_i.action == ACT_CUBIC);
        seg_d = '{c1: in_c1, c2: (cmd_i.action == ACT_CUBIC) ? in_c2 : in_c1, e: in_e};
        if (cmd_i.valid) begin
          case (cmd_i.action)
            ACT_BEGIN: begin
              cur_d = '0;
              start_d = '0;
            end
            ACT_MOVE: begin
              cur_d = in_e;
              start_d = in_e;
            end
            ACT_CLOSE: seg_d.e = start_q;
            default: ;
          endcase
        end
      end
      ST_SQX: sq_d = prod;
      ST_SQY: begin
        rad_d = sq_q + prod;
        rem_d = '0;
        root_d = '0;
        it_d = '0;
      end
      ST_ROOT: begin
        rad_d = {rad_q[SQ_W-3:0], 2'b00};
        it_d = it_q + 5'd1;
        if (rem_sh >= trial) begin
          rem_d = rem_sh - trial;
          root_d = {root_q[DIST_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          root_d = {root_q[DIST_W-2:0], 1'b0};
        end
        if (it_q == 5'(ROOT_STEPS - 1)) begin
          if (didx_q == 2'd0) begin
            chord_d = root_d;
          end else begin
            poly_d = poly_q + POLY_W'(root_d);
          end
          didx_d = didx_q + 2'd1;
        end
      end
      ST_SPLIT: begin
        seg_d = left;
        level_d = level_q + LVL_W'(1);
        depth_d = depth_q + LVL_W'(1);
        didx_d = '0;
        poly_d = '0;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pt_d = seg_q.e;
          out_last_d = (level_q == '0);
          cur_d = seg_q.e;
        end
      end
      ST_POP: begin
        depth_d = level_q;
        level_d = level_q - LVL_W'(1);
      end
      ST_LOAD: begin
        seg_d = ram_rdata;
        didx_d = '0;
        poly_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q <= '0;
      start_q <= '0;
      level_q <= '0;
      depth_q <= '0;
      out_valid_q <= 1'b0;
      ff_q <= FF_RESET;
      thr_q <= THR_RESET;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      start_q <= start_d;
      level_q <= level_d;
      depth_q <= depth_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.index == REG_FLATNESS) begin
        ff_q <= cfg_i.data[FF_W-1:0];
      end
      if (cfg_i.valid && cfg_i.index == REG_PIXEL) begin
        thr_q <= cfg_i.data[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    cubic_q <= cubic_d;
    didx_q <= didx_d;
    sq_q <= sq_d;
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
    it_q <= it_d;
    chord_q <= chord_d;
    poly_q <= poly_d;
    emit_last_q <= emit_last_d;
    out_pt_q <= out_pt_d;
    out_last_q <= out_last_d;
  end

  `BPF_ASSERT(a_level_bound, level_q <= LVL_W'(MAX_DEPTH))
  `BPF_ASSERT(a_split_room, state_q == ST_SPLIT |-> (depth_q < LVL_W'(MAX_DEPTH) && level_q < LVL_W'(MAX_DEPTH)))
  `BPF_ASSERT(a_idle_empty, state_q == ST_IDLE |-> level_q == '0)
  `BPF_ASSERT(a_emit_loads, (state_q == ST_EMIT && out_free) |=> out_valid_q)
endmodule
